/* rtl/core/page_frame_free_list_allocator_unit_macros.svh */
// Assertion macros of the page frame allocator RTL.
// Included by pffa_ctrl, which checks its own logic; no other dependencies.
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Condition holds at every clock edge outside reset.
`define PFFA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PFFA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PFFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PFFA_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define PFFA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define PFFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/core/pffa_pkg.sv */
// Shared types, codes and constants of the page frame allocator.
// No dependencies; used by all files but pffa_ram and the macros.
package pffa_pkg;

   localparam int NUM_FRAMES_DEFAULT = 4096;

   localparam int BASE_W     = 28;
   localparam int COUNT_W    = 13;
   localparam int TYPE_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 13'd4096;

   // Register index, taken from byte address bit 2.
   localparam logic REG_BASE_FRAME  = 1'b0;
   localparam logic REG_FRAME_COUNT = 1'b1;

   typedef enum logic [TYPE_W-1:0] {
      REQ_INIT  = 2'd0,
      REQ_ALLOC = 2'd1,
      REQ_RUN   = 2'd2,
      REQ_FREE  = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_BAD   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_FREE,
      ST_POP,
      ST_WALK,
      ST_UNLINK,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [BASE_W-1:0]  base_frame;
      logic [COUNT_W-1:0] frame_count;
   } cfg_type;

endpackage

/* rtl/core/pffa_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// Standalone; used for the free list link table.
module pffa_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/pffa_csr.sv */
// Configuration registers of the page frame allocator behind an APB-style port.
// Depends on pffa_pkg for widths, register indexes and the config struct.
module pffa_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pffa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pffa_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pffa_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output pffa_pkg::cfg_type                   cfg
);

   logic [pffa_pkg::BASE_W-1:0]  base_ff, base_in;
   logic [pffa_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         wr_fire;
   logic                         reg_index;

   assign csr_pready = 1'b1;
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[2];

   always_comb begin
      base_in  = base_ff;
      count_in = count_ff;
      if (wr_fire) begin
         if (reg_index == pffa_pkg::REG_BASE_FRAME) begin
            base_in = csr_pwdata[pffa_pkg::BASE_W-1:0];
         end else begin
            count_in = csr_pwdata[pffa_pkg::COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         count_ff <= pffa_pkg::FRAME_COUNT_RESET;
      end else begin
         base_ff  <= base_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      if (reg_index == pffa_pkg::REG_BASE_FRAME) begin
         csr_prdata = pffa_pkg::CSR_DATA_W'(base_ff);
      end else begin
         csr_prdata = pffa_pkg::CSR_DATA_W'(count_ff);
      end
   end

   assign cfg.base_frame  = base_ff;
   assign cfg.frame_count = count_ff;

endmodule

/* rtl/core/pffa_ctrl.sv */
// Request sequencer of the page frame allocator: list head, run search and
// result register; drives the link table RAM. Depends on pffa_pkg and the macros.
`include "page_frame_free_list_allocator_unit_macros.svh"

module pffa_ctrl #(
   parameter int NUM_FRAMES = pffa_pkg::NUM_FRAMES_DEFAULT,
   localparam int IW = $clog2(NUM_FRAMES + 1),
   localparam int AW = $clog2(NUM_FRAMES)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pffa_pkg::cfg_type                  cfg,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pffa_pkg::TYPE_W-1:0]        req_type,
   input  logic [pffa_pkg::BASE_W-1:0]        free_frame,
   input  logic [pffa_pkg::COUNT_W-1:0]       run_length,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pffa_pkg::STATUS_W-1:0]      status,
   output logic [pffa_pkg::BASE_W-1:0]        frame,
   output logic                               wr_en,
   output logic [AW-1:0]                      wr_addr,
   output logic [IW-1:0]                      wr_data,
   output logic [AW-1:0]                      rd_addr,
   input  logic [IW-1:0]                      rd_data
);

   localparam int CW = (IW > pffa_pkg::COUNT_W) ? IW : pffa_pkg::COUNT_W;
   localparam logic [IW-1:0] END_MARK = IW'(NUM_FRAMES);

   pffa_pkg::state_type state_ff, state_in;

   logic [IW-1:0]                   head_ff, head_in;
   logic [IW-1:0]                   cur_ff, cur_in;     // also free offset and init index
   logic [IW-1:0]                   prev_ff, prev_in;
   logic [IW-1:0]                   start_ff, start_in;
   logic [IW-1:0]                   steps_ff, steps_in;
   logic [pffa_pkg::COUNT_W-1:0]    found_ff, found_in;
   logic [pffa_pkg::COUNT_W-1:0]    len_ff, len_in;
   pffa_pkg::status_type            code_ff, code_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   pffa_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [pffa_pkg::BASE_W-1:0]     rsp_frame_ff, rsp_frame_in;

   logic                            accept;
   logic                            out_free;
   logic                            rsp_load;
   pffa_pkg::status_type            load_status;
   logic [pffa_pkg::BASE_W-1:0]     load_frame;
   logic [IW-1:0]                   size;
   logic [pffa_pkg::BASE_W-1:0]     offset;
   logic                            free_ok;
   logic                            len_bad;
   logic                            head_empty;
   logic [IW-1:0]                   nxt;
   logic [IW-1:0]                   cur_inc;
   logic [pffa_pkg::COUNT_W-1:0]    found_inc;

   // Region size is frame_count clamped to the table depth.
   assign size = (CW'(cfg.frame_count) > CW'(NUM_FRAMES)) ? END_MARK : IW'(cfg.frame_count);

   assign req_tready = (state_ff == pffa_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign offset     = free_frame - cfg.base_frame;
   assign free_ok    = (free_frame >= cfg.base_frame) &&
                       (offset < pffa_pkg::BASE_W'(size));
   assign len_bad    = (run_length == '0) || (CW'(run_length) > CW'(size));
   assign head_empty = (head_ff >= END_MARK);

   // Any stored link at or beyond the table depth ends the list.
   assign nxt        = (rd_data >= END_MARK) ? END_MARK : rd_data;
   assign cur_inc    = cur_ff + 1'b1;
   assign found_inc  = found_ff + 1'b1;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      start_in    = start_ff;
      steps_in    = steps_ff;
      found_in    = found_ff;
      len_in      = len_ff;
      code_in     = code_ff;
      wr_en       = 1'b0;
      wr_addr     = cur_ff[AW-1:0];
      wr_data     = head_ff;
      rd_addr     = head_ff[AW-1:0];
      rsp_load    = 1'b0;
      load_status = pffa_pkg::STATUS_OK;
      load_frame  = '0;

      case (state_ff)
         pffa_pkg::ST_IDLE: begin
            if (accept) begin
               case (pffa_pkg::req_code_type'(req_type))
                  pffa_pkg::REQ_INIT: begin
                     cur_in   = '0;
                     state_in = pffa_pkg::ST_INIT;
                  end
                  pffa_pkg::REQ_FREE: begin
                     if (free_ok) begin
                        cur_in   = offset[IW-1:0];
                        state_in = pffa_pkg::ST_FREE;
                     end else begin
                        code_in  = pffa_pkg::STATUS_BAD;
                        state_in = pffa_pkg::ST_RESULT;
                     end
                  end
                  default: begin
                     if ((pffa_pkg::req_code_type'(req_type) == pffa_pkg::REQ_RUN) && len_bad)
                     begin
                        code_in  = pffa_pkg::STATUS_BAD;
                        state_in = pffa_pkg::ST_RESULT;
                     end else if (head_empty) begin
                        code_in  = pffa_pkg::STATUS_EMPTY;
                        state_in = pffa_pkg::ST_RESULT;
                     end else if ((pffa_pkg::req_code_type'(req_type) == pffa_pkg::REQ_ALLOC) ||
                                  (run_length == pffa_pkg::COUNT_W'(1))) begin
                        state_in = pffa_pkg::ST_POP;
                     end else begin
                        // The link of the head is read now and arrives in the first walk cycle.
                        cur_in   = head_ff;
                        start_in = head_ff;
                        prev_in  = END_MARK;
                        found_in = pffa_pkg::COUNT_W'(1);
                        steps_in = '0;
                        len_in   = run_length;
                        state_in = pffa_pkg::ST_WALK;
                     end
                  end
               endcase
            end
         end

         pffa_pkg::ST_INIT: begin
            if (cur_ff < size) begin
               wr_en   = 1'b1;
               wr_addr = cur_ff[AW-1:0];
               wr_data = (cur_inc < size) ? cur_inc : END_MARK;
               cur_in  = cur_inc;
            end else if (out_free) begin
               head_in  = (size == '0) ? END_MARK : '0;
               rsp_load = 1'b1;
               state_in = pffa_pkg::ST_IDLE;
            end
         end

         pffa_pkg::ST_FREE: begin
            if (out_free) begin
               wr_en    = 1'b1;
               wr_addr  = cur_ff[AW-1:0];
               wr_data  = head_empty ? END_MARK : head_ff;
               head_in  = cur_ff;
               rsp_load = 1'b1;
               state_in = pffa_pkg::ST_IDLE;
            end
         end

         pffa_pkg::ST_POP: begin
            rd_addr = head_ff[AW-1:0];
            if (out_free) begin
               head_in    = nxt;
               rsp_load   = 1'b1;
               load_frame = cfg.base_frame + pffa_pkg::BASE_W'(head_ff);
               state_in   = pffa_pkg::ST_IDLE;
            end
         end

         pffa_pkg::ST_WALK: begin
            // One list step a cycle: the link just read becomes the next read address.
            rd_addr = nxt[AW-1:0];
            if ((nxt == END_MARK) || (steps_ff >= END_MARK)) begin
               code_in  = pffa_pkg::STATUS_EMPTY;
               state_in = pffa_pkg::ST_RESULT;
            end else begin
               steps_in = steps_ff + 1'b1;
               cur_in   = nxt;
               if (nxt == cur_inc) begin
                  found_in = found_inc;
                  if (found_inc == len_ff) begin
                     state_in = pffa_pkg::ST_UNLINK;
                  end
               end else begin
                  prev_in  = cur_ff;
                  start_in = nxt;
                  found_in = pffa_pkg::COUNT_W'(1);
               end
            end
         end

         pffa_pkg::ST_UNLINK: begin
            // The read data here is the link that follows the last frame of the run.
            rd_addr = cur_ff[AW-1:0];
            if (out_free) begin
               if (prev_ff != END_MARK) begin
                  wr_en   = 1'b1;
                  wr_addr = prev_ff[AW-1:0];
                  wr_data = nxt;
               end else begin
                  head_in = nxt;
               end
               rsp_load   = 1'b1;
               load_frame = cfg.base_frame + pffa_pkg::BASE_W'(start_ff);
               state_in   = pffa_pkg::ST_IDLE;
            end
         end

         pffa_pkg::ST_RESULT: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               load_status = code_ff;
               state_in    = pffa_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pffa_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_frame_in  = rsp_frame_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = load_status;
         rsp_frame_in  = load_frame;
      end else if (rsp_tready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pffa_pkg::ST_IDLE;
         head_ff      <= END_MARK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      start_ff      <= start_in;
      steps_ff      <= steps_in;
      found_ff      <= found_in;
      len_ff        <= len_in;
      code_ff       <= code_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign status     = rsp_status_ff;
   assign frame      = rsp_frame_ff;

   `PFFA_ASSERT_IMPLY(a_pop_head_valid, clock, reset, state_ff == pffa_pkg::ST_POP, head_ff != END_MARK, "pop with empty list")
   `PFFA_ASSERT_IMPLY(a_walk_count, clock, reset, state_ff == pffa_pkg::ST_WALK, (found_ff != '0) && (found_ff < len_ff), "run counter out of range")
   `PFFA_ASSERT_IMPLY(a_no_result_overwrite, clock, reset, rsp_valid_ff && !rsp_tready, !rsp_load, "pending result overwritten")
   `PFFA_ASSERT_IMPLY(a_read_only_walk, clock, reset, (state_ff == pffa_pkg::ST_WALK) || (state_ff == pffa_pkg::ST_POP), !wr_en, "link written during a read-only phase")
   `PFFA_ASSERT_IMPLY(a_init_bound, clock, reset, state_ff == pffa_pkg::ST_INIT, cur_ff <= size, "init index past region")

endmodule

/* rtl/core/page_frame_free_list_allocator_unit.sv */
// Top level of the page frame allocator: stream ports, CSR block, sequencer
// and link table RAM. Depends on pffa_pkg, pffa_csr, pffa_ctrl and pffa_ram.
//
// Usage: each request transaction on req_* yields exactly one response
// transaction on rsp_*, in order. req_tuser carries the request code (init,
// alloc one, alloc run, free); req_tdata carries the frame to free and the
// run length. rsp_tuser carries the status, rsp_tdata the first frame.
// Alloc one and free do one link table read or write, then load the result
// register. Init writes one link per cycle over the region. A run allocation
// follows the list one link per cycle through the RAM's registered read port
// and then unlinks the run it found. Rejected requests go straight to the
// result register. The response is valid in the cycle after the last step.
// One request is worked on at a time; a new one is taken while a finished
// response still waits, and its completion holds until the output register
// drains when rsp_tready is low. Reset empties the free list and loads the
// CSR reset values; the link table is not cleared, so the user must issue an
// init before first use (unchecked). Configuration is to be written by the
// user only while no request is pending; the block itself does not enforce this.
module page_frame_free_list_allocator_unit #(
   parameter int NUM_FRAMES = pffa_pkg::NUM_FRAMES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [47:0]                       req_tdata,   // free_frame[27:0], run_length[40:28]
   input  logic [pffa_pkg::TYPE_W-1:0]       req_tuser,   // req_type[1:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,   // frame[27:0]
   output logic [pffa_pkg::STATUS_W-1:0]     rsp_tuser,   // status[1:0]
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pffa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pffa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pffa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int IW = $clog2(NUM_FRAMES + 1);
   localparam int AW = $clog2(NUM_FRAMES);

   pffa_pkg::cfg_type              cfg;
   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   logic [IW-1:0]                  wr_data;
   logic [AW-1:0]                  rd_addr;
   logic [IW-1:0]                  rd_data;
   logic [pffa_pkg::BASE_W-1:0]    rsp_frame;

   pffa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pffa_ctrl #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .free_frame (req_tdata[27:0]),
      .run_length (req_tdata[40:28]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (rsp_tuser),
      .frame      (rsp_frame),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   pffa_ram #(
      .WIDTH (IW),
      .DEPTH (NUM_FRAMES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tdata = 32'(rsp_frame);

endmodule

/* tb/sv/frame_allocator_checker.sv */
// Checker for the page frame allocator: follows the request, response and CSR traffic,
// keeps its own copy of the free list and compares every response field by field.
// Depends on pffa_pkg for field widths, request codes, status codes and register indexes.
module frame_allocator_checker #(
   parameter int NUM_FRAMES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [47:0]                       req_tdata,   // free_frame[27:0], run_length[40:28]
   input  logic [pffa_pkg::TYPE_W-1:0]       req_tuser,   // req_type[1:0]
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [31:0]                       rsp_tdata,   // frame[27:0]
   input  logic [pffa_pkg::STATUS_W-1:0]     rsp_tuser,   // status[1:0]
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic                              csr_pready,
   input  logic [pffa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pffa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic [pffa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  logic                              end_check,
   output int                                fail_count
);
   import pffa_pkg::*;

   localparam int LINK_W = $clog2(NUM_FRAMES + 1);
   localparam logic [LINK_W-1:0] END_LINK = LINK_W'(NUM_FRAMES);

   typedef struct packed {
      status_type        status;
      logic [BASE_W-1:0] frame;
   } grant_t;

   logic [LINK_W-1:0]  next_link [NUM_FRAMES];
   logic [LINK_W-1:0]  free_head;
   logic [BASE_W-1:0]  base_reg;
   logic [COUNT_W-1:0] count_reg;
   grant_t             pending_grants [$];
   int                 mismatches = 0;
   bit                 end_done = 0;

   assign fail_count = mismatches;

   // A stored link at or beyond the table size counts as the end of the list.
   function automatic int unsigned follow_link(input int unsigned idx);
      if (idx >= NUM_FRAMES) begin
         return NUM_FRAMES;
      end
      if (next_link[idx] >= NUM_FRAMES) begin
         return NUM_FRAMES;
      end
      return next_link[idx];
   endfunction

   task automatic apply_request(input req_code_type kind, input logic [BASE_W-1:0] ffr,
                                input logic [COUNT_W-1:0] len, output grant_t grant);
      int unsigned size, off, prev, start, cur, nxt, found, steps;
      bit ok;
      size = (count_reg > NUM_FRAMES) ? NUM_FRAMES : count_reg;
      grant.status = STATUS_OK;
      grant.frame = '0;
      if (kind == REQ_INIT) begin
         for (int unsigned i = 0; i < size; i++) begin
            next_link[i] = (i + 1 < size) ? LINK_W'(i + 1) : END_LINK;
         end
         free_head = (size != 0) ? '0 : END_LINK;
      end else if (kind == REQ_FREE) begin
         off = ffr - base_reg;
         if (ffr < base_reg || off >= size) begin
            grant.status = STATUS_BAD;
         end else begin
            next_link[off] = (free_head >= NUM_FRAMES) ? END_LINK : free_head;
            free_head = LINK_W'(off);
         end
      end else if (kind == REQ_RUN && (len == 0 || len > size)) begin
         grant.status = STATUS_BAD;
      end else if (free_head >= NUM_FRAMES) begin
         grant.status = STATUS_EMPTY;
      end else if (kind == REQ_ALLOC || len == 1) begin
         grant.frame = base_reg + BASE_W'(free_head);
         free_head = LINK_W'(follow_link(free_head));
      end else begin
         // Look for the first stretch of list neighbors whose indexes rise by one.
         prev = NUM_FRAMES;
         start = free_head;
         cur = free_head;
         found = 1;
         steps = 0;
         ok = 1'b1;
         while (ok && found < len) begin
            nxt = follow_link(cur);
            if (nxt == NUM_FRAMES || steps >= NUM_FRAMES) begin
               ok = 1'b0;
            end else begin
               steps++;
               if (nxt == cur + 1) begin
                  found++;
                  cur = nxt;
               end else begin
                  prev = cur;
                  start = nxt;
                  cur = nxt;
                  found = 1;
               end
            end
         end
         if (!ok) begin
            grant.status = STATUS_EMPTY;
         end else begin
            if (prev != NUM_FRAMES) begin
               next_link[prev] = LINK_W'(follow_link(cur));
            end else begin
               free_head = LINK_W'(follow_link(cur));
            end
            grant.frame = base_reg + BASE_W'(start);
         end
      end
   endtask

   task automatic report(input string what, input logic [31:0] expv, input logic [31:0] actv);
      mismatches++;
      if (mismatches <= 10) begin
         $display("allocator mismatch (%s): expected %0h, got %0h", what, expv, actv);
      end
   endtask

   always @(posedge clock) begin
      grant_t grant;
      logic [31:0] reg_value;
      if (reset) begin
         for (int i = 0; i < NUM_FRAMES; i++) begin
            next_link[i] = '0;
         end
         free_head = END_LINK;
         base_reg = '0;
         count_reg = FRAME_COUNT_RESET;
         pending_grants.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_grants.size() == 0) begin
               report("response with no request waiting", 32'h0, rsp_tdata);
            end else begin
               grant = pending_grants.pop_front();
               if (rsp_tuser !== grant.status) begin
                  report("status", grant.status, rsp_tuser);
               end
               if (rsp_tdata[BASE_W-1:0] !== grant.frame) begin
                  report("frame", grant.frame, rsp_tdata[BASE_W-1:0]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_request(req_code_type'(req_tuser), req_tdata[BASE_W-1:0],
                          req_tdata[BASE_W+COUNT_W-1:BASE_W], grant);
            pending_grants.push_back(grant);
         end
         if (csr_psel && csr_penable && csr_pready) begin
            reg_value = (csr_paddr[2] == REG_FRAME_COUNT) ? 32'(count_reg) : 32'(base_reg);
            if (csr_pwrite) begin
               if (csr_paddr[2] == REG_FRAME_COUNT) begin
                  count_reg = csr_pwdata[COUNT_W-1:0];
               end else begin
                  base_reg = csr_pwdata[BASE_W-1:0];
               end
            end else if (csr_prdata !== reg_value) begin
               report("register read", reg_value, csr_prdata);
            end
         end
         if (end_check && !end_done) begin
            end_done = 1'b1;
            if (pending_grants.size() != 0) begin
               mismatches += pending_grants.size();
               $display("allocator: %0d responses never arrived", pending_grants.size());
            end
         end
      end
   end

endmodule

/* tb/sv/testbench.sv */
// Top of the page frame allocator testbench: clock, reset, request and CSR stimulus,
// response back-pressure and the verdict. Depends on pffa_pkg, the allocator top level
// and frame_allocator_checker.
module testbench;
   import pffa_pkg::*;

   localparam int NUM_FRAMES = 4096;
   localparam logic [BASE_W-1:0] FRAME_MASK = '1;

   typedef struct {
      req_code_type       kind;
      logic [COUNT_W-1:0] len;
      int                 epoch;
   } issued_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [47:0]           req_tdata = '0;
   logic [TYPE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  end_check = 1'b0;
   int                    fail_count;

   // Stimulus bookkeeping: requests in flight and frames known to be allocated.
   issued_t           inflight_requests [$];
   logic [BASE_W-1:0] owned_frames [$];
   int                epoch = 0;
   int                burst_left = 0;
   logic [BASE_W-1:0] cur_base = '0;
   int unsigned       cur_size = NUM_FRAMES;
   int                stall_mode = 0;
   int                mode_left = 0;
   int                stall_phase = 0;

   page_frame_free_list_allocator_unit #(.NUM_FRAMES(NUM_FRAMES)) DUT (.*);

   frame_allocator_checker #(.NUM_FRAMES(NUM_FRAMES)) checker_inst (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The response side switches between free flow, random stalls and sparse acceptance.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      stall_phase++;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (stall_phase % 4 == 0);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Frames granted in the current epoch become candidates for later frees.
   always @(posedge clock) begin
      issued_t entry;
      if (!reset && rsp_tvalid && rsp_tready && inflight_requests.size() != 0) begin
         entry = inflight_requests.pop_front();
         if (entry.epoch == epoch && rsp_tuser == STATUS_OK) begin
            if (entry.kind == REQ_ALLOC) begin
               owned_frames.push_back(rsp_tdata[BASE_W-1:0]);
            end else if (entry.kind == REQ_RUN) begin
               for (int k = 0; k < entry.len; k++) begin
                  owned_frames.push_back(rsp_tdata[BASE_W-1:0] + BASE_W'(k));
               end
            end
         end
      end
   end

   task automatic send_request(input req_code_type kind, input logic [BASE_W-1:0] ffr,
                               input logic [COUNT_W-1:0] len);
      issued_t entry;
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      if (kind == REQ_INIT) begin
         // Init relinks everything, so earlier grants no longer count as owned.
         owned_frames.delete();
         epoch++;
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'b0, len, ffr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      entry.kind = kind;
      entry.len = len;
      entry.epoch = epoch;
      inflight_requests.push_back(entry);
      burst_left--;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic finish_burst();
      if (burst_left > 0) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
      end
   endtask

   task automatic drain();
      finish_burst();
      while (inflight_requests.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic reg_sel,
                             input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic reconfigure(input logic [BASE_W-1:0] base, input logic [COUNT_W-1:0] count);
      drain();
      csr_access(1'b1, REG_BASE_FRAME, 32'(base));
      csr_access(1'b1, REG_FRAME_COUNT, 32'(count));
      csr_access(1'b0, REG_BASE_FRAME, '0);
      csr_access(1'b0, REG_FRAME_COUNT, '0);
      cur_base = base;
      cur_size = (count > NUM_FRAMES) ? NUM_FRAMES : count;
      owned_frames.delete();
      epoch++;
   endtask

   function automatic logic [BASE_W-1:0] junk_frame();
      return BASE_W'($urandom);
   endfunction

   function automatic logic [COUNT_W-1:0] junk_length();
      return COUNT_W'($urandom);
   endfunction

   // Mostly allocs, frees of owned frames and short runs, rare inits; a little noise
   // outside the region, bad lengths and the occasional free of any frame near the base.
   task automatic random_requests(input int count);
      int pick, slot;
      int unsigned cap;
      logic [BASE_W-1:0] ffr;
      logic [COUNT_W-1:0] len;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            send_request(REQ_INIT, junk_frame(), junk_length());
         end else if (pick < 35) begin
            send_request(REQ_ALLOC, junk_frame(), junk_length());
         end else if (pick < 60) begin
            cap = (cur_size < 6) ? cur_size : 6;
            case ($urandom_range(0, 9))
               0: begin
                  case ($urandom_range(0, 3))
                     0: len = '0;
                     1: len = COUNT_W'(cur_size + 1);
                     2: len = '1;
                     default: len = junk_length();
                  endcase
               end
               1: len = (cur_size == 0) ? '0 : COUNT_W'($urandom_range(1, cur_size));
               default: len = (cap == 0) ? COUNT_W'(1) : COUNT_W'($urandom_range(1, cap));
            endcase
            send_request(REQ_RUN, junk_frame(), len);
         end else begin
            if (pick < 97 && owned_frames.size() != 0) begin
               slot = $urandom_range(0, owned_frames.size() - 1);
               ffr = owned_frames[slot];
               owned_frames.delete(slot);
            end else begin
               case ($urandom_range(0, 3))
                  0: ffr = junk_frame();
                  1: ffr = cur_base - 1'b1;
                  2: ffr = cur_base + BASE_W'(cur_size);
                  default: ffr = cur_base + BASE_W'($urandom_range(0, 63));
               endcase
            end
            send_request(REQ_FREE, ffr, junk_length());
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, REG_BASE_FRAME, '0);
      csr_access(1'b0, REG_FRAME_COUNT, '0);

      // Reset register values: empty list, bad lengths and frees outside the region.
      send_request(REQ_ALLOC, junk_frame(), junk_length());
      send_request(REQ_RUN, '0, 13'd2);
      send_request(REQ_RUN, FRAME_MASK, 13'd0);
      send_request(REQ_RUN, '0, 13'd4097);
      send_request(REQ_RUN, '0, '1);
      send_request(REQ_FREE, FRAME_MASK, '1);
      send_request(REQ_FREE, 28'd4096, '0);
      send_request(REQ_INIT, junk_frame(), junk_length());
      send_request(REQ_ALLOC, junk_frame(), junk_length());
      send_request(REQ_RUN, '0, 13'd1);
      send_request(REQ_RUN, '0, 13'd4);
      send_request(REQ_FREE, 28'd0, '0);
      send_request(REQ_FREE, 28'd1, '0);
      send_request(REQ_RUN, '0, 13'd2);
      send_request(REQ_RUN, '0, 13'd4096);
      // Freeing the head again links it to itself; the run walk must give up.
      send_request(REQ_FREE, 28'd1, '0);
      send_request(REQ_RUN, '0, 13'd3);
      send_request(REQ_ALLOC, junk_frame(), junk_length());
      send_request(REQ_INIT, junk_frame(), junk_length());
      epoch++;
      random_requests(30);

      // Region just below the top of the frame space, so grants wrap around.
      reconfigure(28'h0FFFFF0, 13'd32);
      reconfigure(28'hFFFFFF0, 13'd32);
      send_request(REQ_INIT, junk_frame(), junk_length());
      send_request(REQ_FREE, 28'hFFFFFEF, '0);
      send_request(REQ_FREE, 28'h0000010, '0);
      send_request(REQ_RUN, '0, 13'd33);
      send_request(REQ_RUN, '0, 13'd32);
      send_request(REQ_ALLOC, junk_frame(), junk_length());
      send_request(REQ_FREE, 28'hFFFFFF0, '0);
      send_request(REQ_FREE, 28'hFFFFFFF, '0);
      send_request(REQ_RUN, '0, 13'd2);
      send_request(REQ_INIT, junk_frame(), junk_length());
      send_request(REQ_RUN, '0, 13'd20);
      send_request(REQ_ALLOC, junk_frame(), junk_length());
      epoch++;
      random_requests(180);

      // Empty region.
      reconfigure('0, 13'd0);
      send_request(REQ_INIT, junk_frame(), junk_length());
      send_request(REQ_ALLOC, junk_frame(), junk_length());
      send_request(REQ_RUN, '0, 13'd1);
      send_request(REQ_FREE, 28'd0, '0);
      random_requests(15);

      reconfigure(junk_frame(), 13'd1);
      random_requests(50);

      // A count above the table size is clamped to the table size.
      reconfigure(FRAME_MASK, '1);
      random_requests(30);

      repeat (4) begin
         reconfigure(junk_frame(), COUNT_W'($urandom_range(2, 64)));
         random_requests(100);
      end

      drain();
      repeat (20) @(posedge clock);
      end_check <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/pffa_pkg.sv
rtl/core/pffa_ram.sv
rtl/core/pffa_csr.sv
rtl/core/pffa_ctrl.sv
rtl/core/page_frame_free_list_allocator_unit.sv
tb/sv/frame_allocator_checker.sv
tb/sv/testbench.sv
